// ===== rtl/core/kfsl_pkg.sv =====
// Package for the keyframe segment locator: field widths, mode and status codes,
// the micro-operation, condition and step encodings, and the control store.
// Depends on nothing; used by kfsl_seq and keyframe_segment_locator_unit.
`default_nettype none

package kfsl_pkg;

	// default sizes for the top-level parameters
	localparam int MAX_KEYS_DEF  = 256;
	localparam int TIME_BITS_DEF = 32;

	// quotient fraction bits; the factor field width follows from them
	localparam int FRAC_BITS = 16;
	localparam int FACTOR_W  = FRAC_BITS + 1;
	localparam logic [FACTOR_W-1:0] FACTOR_ONE = FACTOR_W'(1) << FRAC_BITS;

	// field widths
	localparam int MODE_W  = 2;
	localparam int DUR_W   = 24;
	localparam int TPOS_W  = 32;
	localparam int KIDX_W  = 8;
	localparam int STAT_W  = 3;
	localparam int IDX_W   = 8;
	localparam int COUNT_W = 9;

	// item modes
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
	localparam logic [MODE_W-1:0] MODE_QTIME  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_QINDEX = 2'd3;

	// result status codes
	localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
	localparam logic [STAT_W-1:0] ST_APPENDED = 3'd1;
	localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
	localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd3;
	localparam logic [STAT_W-1:0] ST_CLEARED  = 3'd4;
	localparam logic [STAT_W-1:0] ST_CLAMPED  = 3'd5;

	// datapath micro-operations
	typedef enum logic [3:0] {
		OP_NOP       = 4'd0,
		OP_ACCEPT    = 4'd1,
		OP_CLEAR     = 4'd2,
		OP_APPEND    = 4'd3,
		OP_EMPTY     = 4'd4,
		OP_SRCH_INIT = 4'd5,
		OP_SRCH_RD   = 4'd6,
		OP_SRCH_UPD  = 4'd7,
		OP_NXT_LO    = 4'd8,
		OP_NXT_KEY   = 4'd9,
		OP_RD_NXT    = 4'd10,
		OP_RD_PRV    = 4'd11,
		OP_LD_T1     = 4'd12,
		OP_ORIENT    = 4'd13,
		OP_EVAL      = 4'd14,
		OP_DIV_STEP  = 4'd15
	} op_t;

	// step hold conditions (handshake stalls)
	typedef enum logic [1:0] {
		H_NONE = 2'd0,
		H_IN   = 2'd1,
		H_OUT  = 2'd2
	} hold_t;

	// jump conditions
	typedef enum logic [3:0] {
		C_NONE      = 4'd0,
		C_ALWAYS    = 4'd1,
		C_MODE_CLR  = 4'd2,
		C_MODE_APP  = 4'd3,
		C_EMPTY     = 4'd4,
		C_MODE_IDX  = 4'd5,
		C_SRCH_DONE = 4'd6,
		C_NO_DIV    = 4'd7,
		C_DIV_MORE  = 4'd8
	} cond_t;

	typedef logic [4:0] step_t;

	// control store addresses
	localparam step_t S_IDLE     = 5'd0;
	localparam step_t S_DISP_CLR = 5'd1;
	localparam step_t S_DISP_APP = 5'd2;
	localparam step_t S_DISP_EMP = 5'd3;
	localparam step_t S_DISP_IDX = 5'd4;
	localparam step_t S_SINIT    = 5'd5;
	localparam step_t S_SRCH     = 5'd6;
	localparam step_t S_SUPD     = 5'd7;
	localparam step_t S_FOUND    = 5'd8;
	localparam step_t S_INDEX    = 5'd9;
	localparam step_t S_PAIR     = 5'd10;
	localparam step_t S_RDPRV    = 5'd11;
	localparam step_t S_LDT1     = 5'd12;
	localparam step_t S_ORIENT   = 5'd13;
	localparam step_t S_EVAL     = 5'd14;
	localparam step_t S_DIV      = 5'd15;
	localparam step_t S_DONE     = 5'd16;
	localparam step_t S_CLEAR    = 5'd17;
	localparam step_t S_APPEND   = 5'd18;
	localparam step_t S_EMPTYQ   = 5'd19;

	// the emit step; not a datapath op, it loads the result register
	typedef struct packed {
		op_t   op;
		logic  emit;
		hold_t hold;
		cond_t cond;
		step_t target;
	} ctrl_t;

	// condition inputs from the datapath to the sequencer
	typedef struct packed {
		logic in_wait;
		logic out_wait;
		logic mode_clr;
		logic mode_app;
		logic empty;
		logic mode_idx;
		logic srch_done;
		logic no_div;
		logic div_more;
	} flags_t;

	// control store
	function automatic ctrl_t ucode(input step_t s);
		ctrl_t c;
		c = '{op: OP_NOP, emit: 1'b0, hold: H_NONE, cond: C_NONE, target: S_IDLE};
		case (s)
			S_IDLE:     c = '{OP_ACCEPT,    1'b0, H_IN,   C_NONE,      S_IDLE};
			S_DISP_CLR: c = '{OP_NOP,       1'b0, H_NONE, C_MODE_CLR,  S_CLEAR};
			S_DISP_APP: c = '{OP_NOP,       1'b0, H_NONE, C_MODE_APP,  S_APPEND};
			S_DISP_EMP: c = '{OP_NOP,       1'b0, H_NONE, C_EMPTY,     S_EMPTYQ};
			S_DISP_IDX: c = '{OP_NOP,       1'b0, H_NONE, C_MODE_IDX,  S_INDEX};
			S_SINIT:    c = '{OP_SRCH_INIT, 1'b0, H_NONE, C_NONE,      S_IDLE};
			S_SRCH:     c = '{OP_SRCH_RD,   1'b0, H_NONE, C_SRCH_DONE, S_FOUND};
			S_SUPD:     c = '{OP_SRCH_UPD,  1'b0, H_NONE, C_ALWAYS,    S_SRCH};
			S_FOUND:    c = '{OP_NXT_LO,    1'b0, H_NONE, C_ALWAYS,    S_PAIR};
			S_INDEX:    c = '{OP_NXT_KEY,   1'b0, H_NONE, C_NONE,      S_IDLE};
			S_PAIR:     c = '{OP_RD_NXT,    1'b0, H_NONE, C_NONE,      S_IDLE};
			S_RDPRV:    c = '{OP_RD_PRV,    1'b0, H_NONE, C_NONE,      S_IDLE};
			S_LDT1:     c = '{OP_LD_T1,     1'b0, H_NONE, C_NONE,      S_IDLE};
			S_ORIENT:   c = '{OP_ORIENT,    1'b0, H_NONE, C_NONE,      S_IDLE};
			S_EVAL:     c = '{OP_EVAL,      1'b0, H_NONE, C_NO_DIV,    S_DONE};
			S_DIV:      c = '{OP_DIV_STEP,  1'b0, H_NONE, C_DIV_MORE,  S_DIV};
			S_DONE:     c = '{OP_NOP,       1'b1, H_OUT,  C_ALWAYS,    S_IDLE};
			S_CLEAR:    c = '{OP_CLEAR,     1'b0, H_NONE, C_ALWAYS,    S_DONE};
			S_APPEND:   c = '{OP_APPEND,    1'b0, H_NONE, C_ALWAYS,    S_DONE};
			S_EMPTYQ:   c = '{OP_EMPTY,     1'b0, H_NONE, C_ALWAYS,    S_DONE};
			default:    c = '{OP_NOP,       1'b0, H_NONE, C_ALWAYS,    S_IDLE};
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/kfsl_seq.sv =====
// Microcode sequencer: step counter, control store lookup, hold and jump logic.
// Depends on kfsl_pkg (control word, condition flags, control store).
`default_nettype none

module kfsl_seq (
	input  wire               clk,
	input  wire               arst_n,
	input  kfsl_pkg::flags_t  flags,
	output kfsl_pkg::ctrl_t   ctrl
);

	kfsl_pkg::step_t upc_q;
	kfsl_pkg::step_t upc_d;
	logic            stall;
	logic            take;

	// current control word
	assign ctrl = kfsl_pkg::ucode(upc_q);

	// hold on a stalled handshake
	always_comb begin
		case (ctrl.hold)
			kfsl_pkg::H_IN:  stall = flags.in_wait;
			kfsl_pkg::H_OUT: stall = flags.out_wait;
			default:         stall = 1'b0;
		endcase
	end

	// jump condition select
	always_comb begin
		case (ctrl.cond)
			kfsl_pkg::C_ALWAYS:    take = 1'b1;
			kfsl_pkg::C_MODE_CLR:  take = flags.mode_clr;
			kfsl_pkg::C_MODE_APP:  take = flags.mode_app;
			kfsl_pkg::C_EMPTY:     take = flags.empty;
			kfsl_pkg::C_MODE_IDX:  take = flags.mode_idx;
			kfsl_pkg::C_SRCH_DONE: take = flags.srch_done;
			kfsl_pkg::C_NO_DIV:    take = flags.no_div;
			kfsl_pkg::C_DIV_MORE:  take = flags.div_more;
			default:               take = 1'b0;
		endcase
	end

	// next step
	always_comb begin
		if (stall) begin
			upc_d = upc_q;
		end else if (take) begin
			upc_d = ctrl.target;
		end else begin
			upc_d = upc_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= kfsl_pkg::S_IDLE;
		end else begin
			upc_q <= upc_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/keyframe_segment_locator_unit.sv =====
// Keyframe segment locator top level: key time table, datapath, result register.
// Depends on kfsl_pkg and kfsl_seq (microcode sequencer).
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+------------------------------------------
//   item     | item_valid / item_ready    | mode, duration, time_pos, key_index, loop
//   result   | result_valid / result_ready| status, prev_index, next_index, factor,
//            |                            | factor_clamped, key_count
//
// One item at a time. A query by time finds its key by a binary search loop on the
// table's single read port; a query by index takes the key from the item. Both then
// run the divider, which yields one quotient bit per cycle. Early-out factors skip
// the divider.
// Reset clears the key count and track length; the table itself is not cleared.
// A result waiting in the output register holds only the final step: the next
// item is taken as soon as that result has been moved into it.
`default_nettype none

module keyframe_segment_locator_unit #(
	parameter int MAX_KEYS  = kfsl_pkg::MAX_KEYS_DEF,
	parameter int TIME_BITS = kfsl_pkg::TIME_BITS_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	// item channel
	input  wire                                item_valid,
	output logic                               item_ready,
	input  wire  [kfsl_pkg::MODE_W-1:0]        mode,
	input  wire  [kfsl_pkg::DUR_W-1:0]         duration,
	input  wire  [kfsl_pkg::TPOS_W-1:0]        time_pos,
	input  wire  [kfsl_pkg::KIDX_W-1:0]        key_index,
	input  wire                                loop,
	// result channel
	output logic                               result_valid,
	input  wire                                result_ready,
	output logic [kfsl_pkg::STAT_W-1:0]        status,
	output logic [kfsl_pkg::IDX_W-1:0]         prev_index,
	output logic [kfsl_pkg::IDX_W-1:0]         next_index,
	output logic [kfsl_pkg::FACTOR_W-1:0]      factor,
	output logic                               factor_clamped,
	output logic [kfsl_pkg::COUNT_W-1:0]       key_count
);

	localparam int IW   = $clog2(MAX_KEYS);
	localparam int CNTW = $clog2(MAX_KEYS + 1);
	localparam int XW   = TIME_BITS + 1;
	localparam int CW   = (TIME_BITS > kfsl_pkg::TPOS_W) ? TIME_BITS : kfsl_pkg::TPOS_W;
	localparam int SW   = ((TIME_BITS > kfsl_pkg::DUR_W) ? TIME_BITS : kfsl_pkg::DUR_W) + 1;
	localparam int KW   = (CNTW > kfsl_pkg::KIDX_W) ? CNTW : kfsl_pkg::KIDX_W;
	localparam int PW   = (IW > kfsl_pkg::IDX_W) ? IW : kfsl_pkg::IDX_W;
	localparam int QW   = (CNTW > kfsl_pkg::COUNT_W) ? CNTW : kfsl_pkg::COUNT_W;
	localparam int DCW  = $clog2(kfsl_pkg::FRAC_BITS);

	localparam logic [TIME_BITS-1:0] TMAX = '1;

	kfsl_pkg::ctrl_t  ctrl;
	kfsl_pkg::flags_t flags;

	// architectural state
	logic [CNTW-1:0]      count_q;
	logic [TIME_BITS-1:0] len_q;
	logic [TIME_BITS-1:0] end_times [MAX_KEYS];
	logic [TIME_BITS-1:0] rd_q;

	// latched item
	logic [kfsl_pkg::MODE_W-1:0] mode_q;
	logic [kfsl_pkg::DUR_W-1:0]  dur_q;
	logic [kfsl_pkg::KIDX_W-1:0] key_q;
	logic                        loop_q;

	// working registers
	logic [XW-1:0]  t_q;
	logic [XW-1:0]  t1_q;
	logic [XW-1:0]  t2_q;
	logic [XW-1:0]  den_q;
	logic [XW-1:0]  r_q;
	logic [IW-1:0]  lo_q;
	logic [IW-1:0]  hi_q;
	logic [IW-1:0]  mid_q;
	logic [IW-1:0]  nxt_q;
	logic [IW-1:0]  prv_q;
	logic           wrap_q;
	logic           eq_q;
	logic           below_q;
	logic [DCW-1:0] dcnt_q;

	// result being built
	logic [kfsl_pkg::STAT_W-1:0]   st_q;
	logic [kfsl_pkg::FACTOR_W-1:0] fac_q;
	logic                          fc_q;

	// output register
	logic                           out_valid_q;
	logic [kfsl_pkg::STAT_W-1:0]    status_q;
	logic [kfsl_pkg::IDX_W-1:0]     prev_index_q;
	logic [kfsl_pkg::IDX_W-1:0]     next_index_q;
	logic [kfsl_pkg::FACTOR_W-1:0]  factor_q;
	logic                           factor_clamped_q;
	logic [kfsl_pkg::COUNT_W-1:0]   key_count_q;

	// combinational helpers
	logic                 item_xfer;
	logic                 emit_go;
	logic                 full;
	logic [SW-1:0]        sum;
	logic [TIME_BITS-1:0] new_len;
	logic [CW-1:0]        tpos_cw;
	logic [TIME_BITS-1:0] tpos_sat;
	logic [IW-1:0]        mid;
	logic [IW-1:0]        last_idx;
	logic                 rd_en;
	logic [IW-1:0]        rd_addr;
	logic                 asc;
	logic [XW:0]          r2;
	logic [XW:0]          rsub;
	logic                 ge;
	logic [PW-1:0]        prv_w;
	logic [PW-1:0]        nxt_w;
	logic [QW-1:0]        cnt_w;

	kfsl_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	// handshakes
	assign item_ready = (ctrl.op == kfsl_pkg::OP_ACCEPT);
	assign item_xfer  = item_valid && item_ready;
	assign emit_go    = ctrl.emit && !(out_valid_q && !result_ready);

	// saturate the query time to the table's time range
	assign tpos_cw  = CW'(time_pos);
	assign tpos_sat = (tpos_cw > CW'(TMAX)) ? TMAX : tpos_cw[TIME_BITS-1:0];

	// saturating track length for an append
	assign full    = (count_q == CNTW'(MAX_KEYS));
	assign sum     = SW'(len_q) + SW'(dur_q);
	assign new_len = (sum > SW'(TMAX)) ? TMAX : sum[TIME_BITS-1:0];

	// search midpoint and last entry
	assign mid      = lo_q + ((hi_q - lo_q) >> 1);
	assign last_idx = IW'(count_q - 1'b1);

	// orientation of the key pair
	assign asc = (t2_q > t1_q);

	// restoring division step
	assign r2   = {r_q, 1'b0};
	assign rsub = r2 - {1'b0, den_q};
	assign ge   = (r2 >= {1'b0, den_q});

	// sequencer conditions
	always_comb begin
		flags.in_wait   = !item_xfer;
		flags.out_wait  = out_valid_q && !result_ready;
		flags.mode_clr  = (mode_q == kfsl_pkg::MODE_CLEAR);
		flags.mode_app  = (mode_q == kfsl_pkg::MODE_APPEND);
		flags.empty     = (count_q == '0);
		flags.mode_idx  = (mode_q == kfsl_pkg::MODE_QINDEX);
		flags.srch_done = (lo_q >= hi_q);
		flags.no_div    = eq_q || below_q || (r_q >= den_q);
		flags.div_more  = (dcnt_q != '0);
	end

	// table read port address
	always_comb begin
		rd_en   = 1'b1;
		rd_addr = mid;
		case (ctrl.op)
			kfsl_pkg::OP_SRCH_RD: rd_addr = mid;
			kfsl_pkg::OP_RD_NXT:  rd_addr = nxt_q;
			kfsl_pkg::OP_RD_PRV:  rd_addr = prv_q;
			default:              rd_en   = 1'b0;
		endcase
	end

	// key time table
	always_ff @(posedge clk) begin
		if (ctrl.op == kfsl_pkg::OP_APPEND && !full) begin
			end_times[count_q[IW-1:0]] <= new_len;
		end
		if (rd_en) begin
			rd_q <= end_times[rd_addr];
		end
	end

	// count, track length and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			len_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.op == kfsl_pkg::OP_CLEAR) begin
				count_q <= '0;
				len_q   <= '0;
			end else if (ctrl.op == kfsl_pkg::OP_APPEND && !full) begin
				count_q <= count_q + 1'b1;
				len_q   <= new_len;
			end
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath working registers
	always_ff @(posedge clk) begin
		case (ctrl.op)
			kfsl_pkg::OP_ACCEPT: begin
				if (item_xfer) begin
					mode_q <= mode;
					dur_q  <= duration;
					key_q  <= key_index;
					loop_q <= loop;
					t_q    <= XW'(tpos_sat);
					st_q   <= kfsl_pkg::ST_OK;
					nxt_q  <= '0;
					prv_q  <= '0;
					fac_q  <= '0;
					fc_q   <= 1'b0;
				end
			end
			kfsl_pkg::OP_CLEAR: begin
				st_q <= kfsl_pkg::ST_CLEARED;
			end
			kfsl_pkg::OP_APPEND: begin
				st_q <= full ? kfsl_pkg::ST_FULL : kfsl_pkg::ST_APPENDED;
			end
			kfsl_pkg::OP_EMPTY: begin
				st_q <= kfsl_pkg::ST_EMPTY;
			end
			kfsl_pkg::OP_SRCH_INIT: begin
				if (t_q > XW'(len_q)) begin
					t_q <= XW'(len_q);
				end
				lo_q <= '0;
				hi_q <= last_idx;
			end
			kfsl_pkg::OP_SRCH_RD: begin
				mid_q <= mid;
			end
			kfsl_pkg::OP_SRCH_UPD: begin
				if (XW'(rd_q) < t_q) begin
					lo_q <= mid_q + 1'b1;
				end else begin
					hi_q <= mid_q;
				end
			end
			kfsl_pkg::OP_NXT_LO: begin
				nxt_q <= lo_q;
			end
			kfsl_pkg::OP_NXT_KEY: begin
				if (KW'(key_q) >= KW'(count_q)) begin
					nxt_q <= last_idx;
					st_q  <= kfsl_pkg::ST_CLAMPED;
				end else begin
					nxt_q <= IW'(key_q);
				end
			end
			kfsl_pkg::OP_RD_NXT: begin
				// first key: previous is itself, or the last key when looping
				if (nxt_q == '0) begin
					wrap_q <= loop_q;
					prv_q  <= loop_q ? last_idx : '0;
				end else begin
					wrap_q <= 1'b0;
					prv_q  <= nxt_q - 1'b1;
				end
			end
			kfsl_pkg::OP_RD_PRV: begin
				if (wrap_q) begin
					t2_q <= XW'(rd_q) + XW'(len_q);
					t_q  <= t_q + XW'(len_q);
				end else begin
					t2_q <= XW'(rd_q);
				end
			end
			kfsl_pkg::OP_LD_T1: begin
				t1_q <= XW'(rd_q);
			end
			kfsl_pkg::OP_ORIENT: begin
				eq_q    <= (t1_q == t2_q);
				den_q   <= asc ? (t2_q - t1_q) : (t1_q - t2_q);
				r_q     <= asc ? (t_q - t1_q) : (t1_q - t_q);
				below_q <= asc ? (t_q < t1_q) : (t_q > t1_q);
			end
			kfsl_pkg::OP_EVAL: begin
				// early outs: equal times, below zero, above or at one
				dcnt_q <= DCW'(kfsl_pkg::FRAC_BITS - 1);
				if (eq_q) begin
					fac_q <= '0;
					fc_q  <= 1'b0;
				end else if (below_q) begin
					fac_q <= '0;
					fc_q  <= 1'b1;
				end else if (r_q > den_q) begin
					fac_q <= kfsl_pkg::FACTOR_ONE;
					fc_q  <= 1'b1;
				end else if (r_q == den_q) begin
					fac_q <= kfsl_pkg::FACTOR_ONE;
					fc_q  <= 1'b0;
				end else begin
					fac_q <= '0;
					fc_q  <= 1'b0;
				end
			end
			kfsl_pkg::OP_DIV_STEP: begin
				r_q    <= ge ? rsub[XW-1:0] : r2[XW-1:0];
				fac_q  <= {fac_q[kfsl_pkg::FACTOR_W-2:0], ge};
				dcnt_q <= dcnt_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

	// result register payload
	assign prv_w = PW'(prv_q);
	assign nxt_w = PW'(nxt_q);
	assign cnt_w = QW'(count_q);

	always_ff @(posedge clk) begin
		if (emit_go) begin
			status_q         <= st_q;
			prev_index_q     <= prv_w[kfsl_pkg::IDX_W-1:0];
			next_index_q     <= nxt_w[kfsl_pkg::IDX_W-1:0];
			factor_q         <= fac_q;
			factor_clamped_q <= fc_q;
			key_count_q      <= cnt_w[kfsl_pkg::COUNT_W-1:0];
		end
	end

	assign result_valid   = out_valid_q;
	assign status         = status_q;
	assign prev_index     = prev_index_q;
	assign next_index     = next_index_q;
	assign factor         = factor_q;
	assign factor_clamped = factor_clamped_q;
	assign key_count      = key_count_q;

	// checks
	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(ctrl.emit))
		else $error("result valid rose without an emit step");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(MAX_KEYS))
		else $error("key count past table depth");

	a_div_remainder: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == kfsl_pkg::OP_DIV_STEP) |-> (r_q < den_q))
		else $error("divider remainder not below denominator");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> !item_ready)
		else $error("second item taken before the first finished");

endmodule

`default_nettype wire
